@@ hdl/rmth_pkg.sv @@
// ----------------------------------------------------------------------------
// rmth_pkg
// shared types and constants for the running median block
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int SIZE_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W      = 32;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               restart;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] median;
        logic               dropped;
    } out_req_t;

    // heap operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;

    // command from controller to a heap datapath
    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic       clear;
        key_t       key;
    } heap_cmd_t;

    // status from a heap datapath
    typedef struct packed {
        logic  busy;
        key_t  top;
        key_t  popped;
        size_t size;
    } heap_sts_t;

endpackage

@@ hdl/rmth_heap.sv @@
// ----------------------------------------------------------------------------
// rmth_heap
// min-heap datapath over one memory: push sifts up, pop sifts down
// ----------------------------------------------------------------------------
module rmth_heap (
    input  logic              clk,
    input  logic              rst_n,
    input  rmth_pkg::heap_cmd_t cmd,
    output rmth_pkg::heap_sts_t sts
);
    import rmth_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_DN1   = 3'd3;
    localparam logic [2:0] S_DN2   = 3'd4;
    localparam logic [2:0] S_PLACE = 3'd5;

    key_t  mem [HEAP_DEPTH];
    key_t  rd_data_reg;
    addr_t rd_addr;
    logic  rd_en;
    addr_t wr_addr;
    key_t  wr_data;
    logic  wr_en;

    logic [2:0] state_reg, state_next;
    size_t size_reg, size_next;
    addr_t idx_reg, idx_next;
    addr_t par_reg, par_next;
    key_t  key_reg, key_next;
    key_t  top_reg, top_next;
    key_t  pop_reg, pop_next;
    key_t  c1_reg, c1_next;
    logic  c2ok_reg, c2ok_next;

    logic [ADDR_W:0] c1_idx;
    logic [ADDR_W:0] c2_idx;
    logic [ADDR_W:0] nxt_c1;
    logic            pick2;
    key_t            best;
    addr_t           best_idx;

    // child selection for the sift down
    always_comb
    begin
        c1_idx   = {idx_reg, 1'b0} + (ADDR_W+1)'(1);
        c2_idx   = c1_idx + (ADDR_W+1)'(1);
        pick2    = c2ok_reg && (rd_data_reg < c1_reg);
        best     = pick2 ? rd_data_reg : c1_reg;
        best_idx = pick2 ? ADDR_W'(c2_idx) : ADDR_W'(c1_idx);
        nxt_c1   = {best_idx, 1'b0} + (ADDR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        par_reg  <= par_next;
        key_reg  <= key_next;
        top_reg  <= top_next;
        pop_reg  <= pop_next;
        c1_reg   <= c1_next;
        c2ok_reg <= c2ok_next;
    end

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        par_next   = par_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        pop_next   = pop_reg;
        c1_next    = c1_reg;
        c2ok_next  = c2ok_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.clear)
                begin
                    size_next = '0;
                end
                else if (cmd.start && cmd.op == OP_PUSH)
                begin
                    key_next  = cmd.key;
                    size_next = size_reg + SIZE_W'(1);
                    if (size_reg == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = cmd.key;
                    end
                    else
                    begin
                        idx_next   = ADDR_W'(size_reg);
                        par_next   = ADDR_W'((size_reg - SIZE_W'(1)) >> 1);
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'((size_reg - SIZE_W'(1)) >> 1);
                        state_next = S_UP;
                    end
                end
                else if (cmd.start && cmd.op == OP_POP && size_reg != '0)
                begin
                    pop_next  = top_reg;
                    size_next = size_reg - SIZE_W'(1);
                    if (size_reg != SIZE_W'(1))
                    begin
                        // fetch the last entry, it refills the root
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(size_reg - SIZE_W'(1));
                        state_next = S_LAST;
                    end
                end
            end
            S_UP:
            begin
                // parent value in rd_data_reg
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (rd_data_reg <= key_reg)
                begin
                    wr_data    = key_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_data  = rd_data_reg;
                    idx_next = par_reg;
                    if (par_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        par_next = (par_reg - ADDR_W'(1)) >> 1;
                        rd_en    = 1'b1;
                        rd_addr  = (par_reg - ADDR_W'(1)) >> 1;
                    end
                end
            end
            S_LAST:
            begin
                key_next = rd_data_reg;
                idx_next = '0;
                if (size_reg == SIZE_W'(1))
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(1);
                    state_next = S_DN1;
                end
            end
            S_DN1:
            begin
                // first child arrived, fetch the second if present
                c1_next   = rd_data_reg;
                c2ok_next = c2_idx < (ADDR_W+1)'(size_reg);
                if (c2_idx < (ADDR_W+1)'(size_reg))
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(c2_idx);
                end
                state_next = S_DN2;
            end
            S_DN2:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (best >= key_reg)
                begin
                    wr_data    = key_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_data  = best;
                    idx_next = best_idx;
                    if (nxt_c1 < (ADDR_W+1)'(size_reg))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(nxt_c1);
                        state_next = S_DN1;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = key_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // keep a copy of the root
        if (wr_en && wr_addr == '0)
        begin
            top_next = wr_data;
        end
    end

    assign sts.busy   = (state_reg != S_IDLE);
    assign sts.top    = top_reg;
    assign sts.popped = pop_reg;
    assign sts.size   = size_reg;

endmodule

@@ hdl/rmth_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmth_ctrl
// sequencer: insert, rebalance, report median
// ----------------------------------------------------------------------------
module rmth_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rmth_pkg::in_req_t   in_req,
    output logic                out_valid,
    input  logic                out_stall,
    output rmth_pkg::out_req_t  out_req,
    output rmth_pkg::heap_cmd_t lo_cmd,
    input  rmth_pkg::heap_sts_t lo_sts,
    output rmth_pkg::heap_cmd_t up_cmd,
    input  rmth_pkg::heap_sts_t up_sts
);
    import rmth_pkg::*;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_INS   = 3'd1;
    localparam logic [2:0] C_WAIT1 = 3'd2;
    localparam logic [2:0] C_BAL   = 3'd3;
    localparam logic [2:0] C_POPW  = 3'd4;
    localparam logic [2:0] C_PUSHW = 3'd5;
    localparam logic [2:0] C_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    key_t key_reg, key_next;
    logic drop_reg, drop_next;
    logic dir_reg, dir_next;     // 1: move lower top to upper
    logic ov_reg, ov_next;
    out_req_t ob_reg, ob_next;
    logic busy;

    assign busy = lo_sts.busy | up_sts.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        drop_reg <= drop_next;
        dir_reg  <= dir_next;
        ob_reg   <= ob_next;
    end

    assign in_stall  = (state_reg != C_IDLE);
    assign out_valid = ov_reg;
    assign out_req   = ob_reg;

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        drop_next  = drop_reg;
        dir_next   = dir_reg;
        ov_next    = ov_reg && out_stall;
        ob_next    = ob_reg;
        lo_cmd     = '0;
        up_cmd     = '0;
        case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    key_next  = {~in_req.sample[31], in_req.sample[30:0]};
                    lo_cmd.clear = in_req.restart;
                    up_cmd.clear = in_req.restart;
                    drop_next = !in_req.restart &&
                        ((SIZE_W+1)'(lo_sts.size) + (SIZE_W+1)'(up_sts.size)
                         >= (SIZE_W+1)'(CAPACITY));
                    state_next = C_INS;
                end
            end
            C_INS:
            begin
                if (drop_reg)
                begin
                    state_next = C_OUT;
                end
                else if (lo_sts.size == '0 || key_reg <= ~lo_sts.top)
                begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.op    = OP_PUSH;
                    lo_cmd.key   = ~key_reg;
                    state_next   = C_WAIT1;
                end
                else
                begin
                    up_cmd.start = 1'b1;
                    up_cmd.op    = OP_PUSH;
                    up_cmd.key   = key_reg;
                    state_next   = C_WAIT1;
                end
            end
            C_WAIT1:
            begin
                if (!busy) state_next = C_BAL;
            end
            C_BAL:
            begin
                if (lo_sts.size > up_sts.size + SIZE_W'(1))
                begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.op    = OP_POP;
                    dir_next     = 1'b1;
                    state_next   = C_POPW;
                end
                else if (up_sts.size > lo_sts.size)
                begin
                    up_cmd.start = 1'b1;
                    up_cmd.op    = OP_POP;
                    dir_next     = 1'b0;
                    state_next   = C_POPW;
                end
                else
                begin
                    state_next = C_OUT;
                end
            end
            C_POPW:
            begin
                if (!busy)
                begin
                    if (dir_reg)
                    begin
                        up_cmd.start = 1'b1;
                        up_cmd.op    = OP_PUSH;
                        up_cmd.key   = ~lo_sts.popped;
                    end
                    else
                    begin
                        lo_cmd.start = 1'b1;
                        lo_cmd.op    = OP_PUSH;
                        lo_cmd.key   = ~up_sts.popped;
                    end
                    state_next = C_PUSHW;
                end
            end
            C_PUSHW:
            begin
                if (!busy) state_next = C_OUT;
            end
            C_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ob_next.dropped = drop_reg;
                    ob_next.median  = (lo_sts.size == '0) ? '0 :
                        $signed({lo_sts.top[31], ~lo_sts.top[30:0]});
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/running_median_two_heaps.sv @@
// ----------------------------------------------------------------------------
// running_median_two_heaps
// lower median of a signed stream, kept in a max-heap and a min-heap
// ----------------------------------------------------------------------------
// timing: a dropped request goes straight to the result; the longest path has
// a sift up, a pop sifting down level by level and a second sift up, each over
// at most 10 heap levels
// throughput: one request at a time; the next is taken once the result is
// registered, a held result lets one more request in
// reset: heap sizes and control clear at once; heap memories are not cleared
module running_median_two_heaps (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rmth_pkg::in_req_t  in_req,
    output logic               out_valid,
    input  logic               out_stall,
    output rmth_pkg::out_req_t out_req
);
    import rmth_pkg::*;

    heap_cmd_t lo_cmd, up_cmd;
    heap_sts_t lo_sts, up_sts;

    // controller drives both heaps through command structs
    rmth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req),
        .lo_cmd    (lo_cmd),
        .lo_sts    (lo_sts),
        .up_cmd    (up_cmd),
        .up_sts    (up_sts)
    );

    // lower half stored as complemented keys so both heaps are min-heaps
    rmth_heap u_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lo_cmd),
        .sts   (lo_sts)
    );

    rmth_heap u_up (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (up_cmd),
        .sts   (up_sts)
    );

    // the two halves stay balanced whenever the block is idle
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall) |-> (lo_sts.size == up_sts.size ||
                         lo_sts.size == up_sts.size + SIZE_W'(1)))
        else $error("heap halves out of balance");

    // a heap is never commanded while it is still sifting
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (lo_sts.busy |-> !lo_cmd.start) and (up_sts.busy |-> !up_cmd.start))
        else $error("heap command while busy");

    // a held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_req)))
        else $error("stalled result changed");

endmodule
